/* hw/rtl/i2a_pkg.sv */
package i2a_pkg;

    localparam int VALUE_W  = 64;
    localparam int KIND_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int DIG_W    = 4;
    localparam int NDIG     = 20;
    localparam int BCD_W    = NDIG * DIG_W;
    localparam int CNT_W    = 5;
    localparam int STEP_W   = 7;
    localparam int IDX_W    = 5;

    localparam logic [STEP_W-1:0] DEC_STEPS  = 7'd64;
    localparam logic [STEP_W-1:0] FOUR_STEPS = 7'd16;
    localparam logic [CNT_W-1:0]  FOUR_LEN   = 5'd4;
    localparam logic [CNT_W-1:0]  HEX_LEN    = 5'd2;
    localparam logic [CNT_W-1:0]  BIN_LEN    = 5'd8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    typedef enum logic [KIND_W-1:0] {
        KIND_SDEC  = 3'd0,
        KIND_FOUR  = 3'd1,
        KIND_HEX   = 3'd2,
        KIND_BTRIM = 3'd3,
        KIND_BFULL = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_TRIM,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                start;
        logic [STEP_W-1:0]   steps;
        logic [VALUE_W-1:0]  mag;
    } dab_req_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [DIG_W-1:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIG_W){1'b0}}, nib};
        if (nib <= 4'd9) begin
            hex_char = wide + ASCII_ZERO;
        end else begin
            hex_char = wide - 8'd10 + ASCII_UPA;
        end
    endfunction

endpackage

/* hw/rtl/i2a_dabble.sv */
module i2a_dabble (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  i2a_pkg::dab_req_t          req,
    output logic                       done,
    output logic [i2a_pkg::BCD_W-1:0]  bcd
);
    import i2a_pkg::*;

    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic [BCD_W-1:0]   adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*DIG_W +: DIG_W] >= 4'd5) begin
                adj[i*DIG_W +: DIG_W] = bcd_reg[i*DIG_W +: DIG_W] + 4'd3;
            end else begin
                adj[i*DIG_W +: DIG_W] = bcd_reg[i*DIG_W +: DIG_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.steps;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            bin_reg <= req.mag;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
        end
    end

    assign done = busy_reg && (cnt_reg == 7'd1);
    assign bcd  = bcd_reg;

    ap_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("conversion restarted while busy");

    ap_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !busy_reg)
        else $error("conversion kept running after its last step");

    ap_nonzero_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != 7'd0)
        else $error("step counter ran out while busy");

endmodule

/* hw/rtl/integer_to_ascii_formatter.sv */
// Formats one number per input beat as ASCII text, most significant
// character first. The slave side carries the 64-bit two's complement value
// in s_tdata and the format kind in s_tuser. The master side carries one
// character per beat in m_tdata, with m_tlast on the final character.
// Kinds are signed decimal, four-digit decimal, two-digit hex byte, trimmed
// binary and eight-digit binary; unused kind codes produce no beats.
// Decimal digits come from one shared shift-and-add-three unit that handles
// one value bit per cycle, over the magnitude of the value for signed decimal
// and over the low 16 bits for the four-digit kind, followed by a trim state
// that finds the leading digit. Characters then leave at one per cycle while
// the receiver takes them. s_tready is high only while the block is idle.
// A stalled receiver holds the current character in the output register and
// pauses emission. Reset returns the block to idle and drops m_tvalid.
module integer_to_ascii_formatter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [i2a_pkg::VALUE_W-1:0]   s_tdata,   // value
    input  logic [i2a_pkg::KIND_W-1:0]    s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [i2a_pkg::CHAR_W-1:0]    m_tdata,   // character
    output logic                          m_tlast
);
    import i2a_pkg::*;

    state_t                       state_reg, state_next;
    kind_t                        kind_reg;
    logic                         neg_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [NDIG-1:0][DIG_W-1:0]   txt_reg;
    logic                         m_tvalid_reg;
    logic [CHAR_W-1:0]            m_tdata_reg;
    logic                         m_tlast_reg;

    dab_req_t                     dab_req;
    logic                         dab_done;
    logic [BCD_W-1:0]             dab_bcd;

    logic                         accept;
    logic                         emit;
    logic                         out_free;
    logic [IDX_W-1:0]             idx;
    logic [CHAR_W-1:0]            emit_char;
    logic                         emit_last;
    logic [NDIG-1:0][DIG_W-1:0]   trim_src;
    logic [CNT_W-1:0]             trim_cnt;
    logic [NDIG-1:0][DIG_W-1:0]   bits_txt;
    logic [NDIG-1:0][DIG_W-1:0]   hex_txt;
    kind_t                        in_kind;

    i2a_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dab_req),
        .done    (dab_done),
        .bcd     (dab_bcd)
    );

    assign in_kind  = kind_t'(s_tuser);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    priority case (in_kind)
                        KIND_SDEC, KIND_FOUR: state_next = S_CONV;
                        KIND_BTRIM:           state_next = S_TRIM;
                        KIND_HEX, KIND_BFULL: state_next = S_EMIT;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_CONV: begin
                if (dab_done) begin
                    state_next = S_TRIM;
                end
            end
            S_TRIM: state_next = S_EMIT;
            S_EMIT: begin
                if (emit && emit_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == S_IDLE);
        accept        = s_tready && s_tvalid;
        emit          = (state_reg == S_EMIT) && out_free;
        dab_req.start = accept && ((in_kind == KIND_SDEC) || (in_kind == KIND_FOUR));
        if (in_kind == KIND_FOUR) begin
            dab_req.steps = FOUR_STEPS;
            dab_req.mag   = {s_tdata[15:0], {(VALUE_W-16){1'b0}}};
        end else begin
            dab_req.steps = DEC_STEPS;
            dab_req.mag   = s_tdata[VALUE_W-1] ? (~s_tdata + 64'd1) : s_tdata;
        end
    end

    always_comb begin
        bits_txt = '0;
        hex_txt  = '0;
        for (int i = 0; i < 8; i++) begin
            bits_txt[i] = {3'b000, s_tdata[i]};
        end
        hex_txt[0] = s_tdata[3:0];
        hex_txt[1] = s_tdata[7:4];
    end

    // The leading digit is the highest nonzero one; zero still shows one digit. Four-digit text keeps four.
    always_comb begin
        if ((kind_reg == KIND_SDEC) || (kind_reg == KIND_FOUR)) begin
            trim_src = dab_bcd;
        end else begin
            trim_src = txt_reg;
        end
        trim_cnt = 5'd1;
        for (int i = 1; i < NDIG; i++) begin
            if (trim_src[i] != 4'd0) begin
                trim_cnt = CNT_W'(i + 1);
            end
        end
        if (kind_reg == KIND_FOUR) begin
            trim_cnt = FOUR_LEN;
        end
    end

    assign idx       = cnt_reg - 5'd1;
    assign emit_char = neg_reg ? ASCII_MINUS : hex_char(txt_reg[idx]);
    assign emit_last = !neg_reg && (cnt_reg == 5'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= in_kind;
            neg_reg  <= (in_kind == KIND_SDEC) && s_tdata[VALUE_W-1];
            unique case (in_kind)
                KIND_HEX: begin
                    txt_reg <= hex_txt;
                    cnt_reg <= HEX_LEN;
                end
                KIND_BTRIM, KIND_BFULL: begin
                    txt_reg <= bits_txt;
                    cnt_reg <= BIN_LEN;
                end
                default: begin
                    txt_reg <= '0;
                    cnt_reg <= 5'd1;
                end
            endcase
        end else if (state_reg == S_TRIM) begin
            txt_reg <= trim_src;
            cnt_reg <= trim_cnt;
        end else if (emit) begin
            if (neg_reg) begin
                neg_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= emit_char;
            m_tlast_reg <= emit_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    ap_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> (cnt_reg != 5'd0) && (cnt_reg <= 5'd20))
        else $error("character count out of range during emission");

    ap_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        dab_done |-> state_reg == S_CONV)
        else $error("conversion finished outside the conversion state");

    ap_last_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && emit_last |=> state_reg == S_IDLE)
        else $error("block did not return to idle after the final character");

    ap_minus_first: assert property (@(posedge aclk) disable iff (!aresetn)
        neg_reg && state_reg == S_EMIT |-> kind_reg == KIND_SDEC)
        else $error("minus sign pending for a kind other than signed decimal");

endmodule

/* tb/sv/ascii_text_checker.sv */
module ascii_text_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [i2a_pkg::VALUE_W-1:0] s_tdata,   // value
    input  logic [i2a_pkg::KIND_W-1:0]  s_tuser,   // kind
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [i2a_pkg::CHAR_W-1:0]  m_tdata,   // character
    input  logic                        m_tlast,
    output int                          failures,
    output int                          pending
);
    import i2a_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_beat_t;

    text_beat_t expected_text[$];
    text_beat_t oldest;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] nib);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIG_W){1'b0}}, nib};
        if (nib < 4'd10) begin
            return ASCII_ZERO + wide;
        end
        return ASCII_UPA + wide - 8'd10;
    endfunction

    function automatic void predict_text(input logic [KIND_W-1:0] kind,
                                         input logic [VALUE_W-1:0] value);
        logic [CHAR_W-1:0] text [NDIG];
        logic [CHAR_W-1:0] reversed [NDIG];
        logic [VALUE_W-1:0] mag;
        logic [15:0]        four;
        logic [7:0]         low_byte;
        logic               seen;
        int                 len;
        int                 nrev;
        int                 i;
        len = 0;
        nrev = 0;
        low_byte = value[7:0];
        case (kind)
            KIND_SDEC: begin
                mag = value;
                if (value[VALUE_W-1]) begin
                    text[len] = ASCII_MINUS;
                    len++;
                    mag = -value;
                end
                do begin
                    reversed[nrev] = digit_char(DIG_W'(mag % 64'd10));
                    mag = mag / 64'd10;
                    nrev++;
                end while (mag != 0);
                for (i = nrev - 1; i >= 0; i--) begin
                    text[len] = reversed[i];
                    len++;
                end
            end
            KIND_FOUR: begin
                four = value[15:0] % 16'd10000;
                text[0] = digit_char(DIG_W'(four / 16'd1000));
                text[1] = digit_char(DIG_W'((four / 16'd100) % 16'd10));
                text[2] = digit_char(DIG_W'((four / 16'd10) % 16'd10));
                text[3] = digit_char(DIG_W'(four % 16'd10));
                len = 4;
            end
            KIND_HEX: begin
                text[0] = digit_char(low_byte[7:4]);
                text[1] = digit_char(low_byte[3:0]);
                len = 2;
            end
            KIND_BTRIM, KIND_BFULL: begin
                seen = (kind == KIND_BFULL);
                for (i = 7; i >= 0; i--) begin
                    if (low_byte[i]) begin
                        seen = 1'b1;
                    end
                    if (seen) begin
                        text[len] = ASCII_ZERO + {7'd0, low_byte[i]};
                        len++;
                    end
                end
                if (len == 0) begin
                    text[0] = ASCII_ZERO;
                    len = 1;
                end
            end
            default: begin
            end
        endcase
        for (i = 0; i < len; i++) begin
            expected_text.push_back({text[i], i == len - 1});
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_text.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_text(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    if (failures < REPORT_LIMIT) begin
                        $display("unexpected beat: character %h last %b", m_tdata, m_tlast);
                    end
                    failures++;
                end else begin
                    oldest = expected_text.pop_front();
                    if (m_tdata !== oldest.character || m_tlast !== oldest.last) begin
                        if (failures < REPORT_LIMIT) begin
                            $display("mismatch: expected character %h last %b, got %h last %b",
                                     oldest.character, oldest.last, m_tdata, m_tlast);
                        end
                        failures++;
                    end
                end
            end
        end
        pending = expected_text.size();
    end

endmodule

/* tb/sv/integer_to_ascii_formatter_test.sv */
module integer_to_ascii_formatter_test;
    import i2a_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES     = 120;
    localparam int ITEMS_PER_PHASE  = 112;
    localparam int SPARE_KIND_PCT   = 5;

    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;
    logic [KIND_W-1:0]  s_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [CHAR_W-1:0]  m_tdata;
    logic               m_tlast;

    int failures;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    integer_to_ascii_formatter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ascii_text_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .failures (failures),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= kind;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] p;
        int                 r;
        case ($urandom_range(4))
            0: v = {$urandom, $urandom};
            1: begin
                r = int'($urandom_range(2000)) - 1000;
                v = {{32{r[31]}}, r};
            end
            2: v = {$urandom, $urandom} >> $urandom_range(63);
            3: begin
                p = 64'd1;
                repeat ($urandom_range(18)) p = p * 64'd10;
                case ($urandom_range(2))
                    0: v = p - 64'd1;
                    1: v = p;
                    default: v = p + 64'd1;
                endcase
                if ($urandom_range(1) == 1) begin
                    v = -v;
                end
            end
            default: begin
                if ($urandom_range(1) == 1) begin
                    v = {1'b1, 63'd0} + 64'($urandom_range(3));
                end else begin
                    v = {1'b0, {63{1'b1}}} - 64'($urandom_range(3));
                end
            end
        endcase
        return v;
    endfunction

    task automatic run_random(input int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < SPARE_KIND_PCT) begin
                send_item(KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)),
                          random_value());
            end else begin
                send_item(KIND_W'($urandom_range(KIND_BFULL)), random_value());
                sent++;
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_SDEC;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(KIND_SDEC, 64'd0);
        send_item(KIND_SDEC, 64'd7);
        send_item(KIND_SDEC, -64'd1);
        send_item(KIND_SDEC, 64'd10);
        send_item(KIND_SDEC, {1'b0, {63{1'b1}}});
        send_item(KIND_SDEC, {1'b1, 63'd0});
        send_item(KIND_SDEC, -64'd1000000);
        send_item(KIND_FOUR, 64'd0);
        send_item(KIND_FOUR, 64'd9999);
        send_item(KIND_FOUR, 64'd10000);
        send_item(KIND_FOUR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_HEX, 64'h0);
        send_item(KIND_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_HEX, 64'h1234_5678_9ABC_DEA5);
        send_item(KIND_BTRIM, 64'h0);
        send_item(KIND_BTRIM, 64'h1);
        send_item(KIND_BTRIM, 64'hFF00_0000_0000_0080);
        send_item(KIND_BTRIM, 64'hFF);
        send_item(KIND_BFULL, 64'h0);
        send_item(KIND_BFULL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(KIND_BFULL, 64'h55);
        send_item(KIND_SPARE_FIRST, 64'd42);
        send_item(KIND_SPARE_MID, {1'b1, 63'd0});
        send_item(KIND_SPARE_LAST, 64'hFFFF_FFFF_FFFF_FFFF);

        run_random(ITEMS_PER_PHASE);
        send_idle_pct = 82;
        run_random(ITEMS_PER_PHASE);
        send_idle_pct = 0;
        recv_stall_pct = 82;
        run_random(ITEMS_PER_PHASE);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        run_random(ITEMS_PER_PHASE);
        s_tvalid <= 1'b0;

        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_dabble.sv
hw/rtl/integer_to_ascii_formatter.sv
tb/sv/ascii_text_checker.sv
tb/sv/integer_to_ascii_formatter_test.sv
